@@ hw/rtl/wmsd_pkg.sv @@
// Shared types and constants for the windowed mean and deviation block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package wmsd_pkg;

  // Default sizes handed down from the top level.
  localparam int unsigned MAX_GROUPS_DEF = 16;
  localparam int unsigned MAX_WINDOW_DEF = 1024;

  // Fixed field widths.
  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned STD_W    = 23;
  localparam int unsigned NUM_W    = 11;
  localparam int unsigned CFG_W    = 23;
  localparam int unsigned CFGIDX_W = 4;

  // Internal datapath widths.
  localparam int unsigned SUM_W  = 36;
  localparam int unsigned DIFF_W = 25;
  localparam int unsigned SQ_W   = 49;
  localparam int unsigned DIV_W  = 60;
  localparam int unsigned ROOT_W = 30;

  // Register indexes on the configuration channel.
  localparam logic [CFGIDX_W-1:0] CFG_WINDOW_LENGTH = 4'd0;
  localparam logic [CFGIDX_W-1:0] CFG_THRESHOLD     = 4'd1;

  // Reset values and fixed results.
  localparam logic [NUM_W-1:0]    WINDOW_LENGTH_RST = 11'd1024;
  localparam logic [STD_W-1:0]    THRESHOLD_RST     = 23'd1049;
  localparam logic [SAMPLE_W-1:0] ONE_Q20           = 24'h100000;
  localparam logic [STD_W-1:0]    STD_MAX           = 23'h7FFFFF;

  // Item codes.
  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // One input word as it travels through the queue.
  typedef struct packed {
    logic                       mode;
    logic [GROUP_W-1:0]         group;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  // Queue output toward the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN_GO,
    ST_DIV_MEAN,
    ST_SQ,
    ST_VAR_GO,
    ST_DIV_VAR,
    ST_SQRT_OUT
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/wmsd_front.sv @@
// Front end: accepts command words and holds them in a two-word queue.
// Depends on wmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wmsd_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  input  wire                   in_mode,
  input  wire [3:0]             in_group,
  input  wire signed [23:0]     in_sample,
  output logic                  busy,
  input  wire                   pop,
  output wmsd_pkg::queue_out_t  qout
);
  import wmsd_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;

  // A word enters when the queue has room; the back end takes from the head.
  assign busy = (count == 2'd2);
  assign push = start && !busy;
  assign take = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (take) rd_ptr <= !rd_ptr;
      unique case ({push, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].mode   <= in_mode;
      slots[wr_ptr].group  <= in_group;
      slots[wr_ptr].sample <= in_sample;
    end
  end

  assign qout.valid = (count != 2'd0);
  assign qout.item  = slots[rd_ptr];

endmodule
`default_nettype wire

@@ hw/rtl/wmsd_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on wmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wmsd_div (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             go,
  input  wire [wmsd_pkg::DIV_W-1:0]       dividend,
  input  wire [wmsd_pkg::NUM_W-1:0]       divisor,
  output logic                            done,
  output logic [wmsd_pkg::DIV_W-1:0]      quot,
  output logic                            rem_nz
);
  import wmsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic [NUM_W-1:0] dvs;
  logic [NUM_W-1:0] rem;
  logic [NUM_W:0]   rem_t;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             running;

  // Trial subtraction of the shifted partial remainder.
  assign rem_t  = {rem, quot[DIV_W-1]};
  assign ge     = (rem_t >= {1'b0, dvs});
  assign rem_nz = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (running) begin
      quot <= {quot[DIV_W-2:0], ge};
      rem  <= ge ? NUM_W'(rem_t - {1'b0, dvs}) : NUM_W'(rem_t);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/wmsd_back.sv @@
// Back end: sample rings, fill counts, the window walk and the result sequencer.
// Depends on wmsd_pkg and wmsd_div.
`timescale 1ns / 1ps
`default_nettype none
module wmsd_back #(
  parameter int unsigned MAX_GROUPS = wmsd_pkg::MAX_GROUPS_DEF,
  parameter int unsigned MAX_WINDOW = wmsd_pkg::MAX_WINDOW_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wmsd_pkg::queue_out_t           qout,
  output logic                           pop,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [wmsd_pkg::CFGIDX_W-1:0]   cfg_index,
  input  wire [wmsd_pkg::CFG_W-1:0]      cfg_data,
  output logic                           done,
  output logic [3:0]                     group_out,
  output logic signed [23:0]             mean,
  output logic [22:0]                    std_dev,
  output logic [10:0]                    sample_count,
  output logic                           converged
);
  import wmsd_pkg::*;

  localparam int unsigned GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned PW    = $clog2(MAX_WINDOW);
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned EW    = (CW > NUM_W) ? CW : NUM_W;
  localparam int unsigned DEPTH = MAX_GROUPS * MAX_WINDOW;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RC_W  = $clog2(ROOT_W + 1);

  state_t state, state_next;

  // Configuration registers.
  logic [NUM_W-1:0] window_length;
  logic [STD_W-1:0] threshold;

  // Per-group ring state.
  logic [CW-1:0] fill_count [MAX_GROUPS];
  logic [PW-1:0] write_pos  [MAX_GROUPS];

  // Sample memory.
  logic signed [SAMPLE_W-1:0] ring [DEPTH];
  logic signed [SAMPLE_W-1:0] rdata;
  logic                       rvalid;

  // Control outputs of the sequencer.
  logic mem_we;
  logic rd_en;
  logic div_go;

  // Head word decode.
  item_t         it;
  logic          g_ok;
  logic [GW-1:0] gidx;
  logic [EW-1:0] eff;
  logic [EW-1:0] fill_ext;
  logic [NUM_W-1:0] n_calc;
  logic [PW-1:0] head_pos;
  logic [AW-1:0] wr_addr;

  // Walk state.
  logic [GROUP_W-1:0] rgroup;
  logic [GW-1:0]      rgidx;
  logic [NUM_W-1:0]   n;
  logic [NUM_W-1:0]   issue_cnt;
  logic [NUM_W-1:0]   acc_cnt;
  logic [PW-1:0]      start_pos;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      pos_dec;
  logic [AW-1:0]      rd_addr;
  logic               empty;
  logic               issuing;

  // Arithmetic.
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic signed [DIFF_W-1:0]   diff;
  logic                       diff_v;
  logic [SQ_W-1:0]            sqr;
  logic                       sqr_v;
  logic [DIV_W-1:0]           sq_acc;
  logic [DIV_W-1:0]           div_in;
  logic [DIV_W-1:0]           quot;
  logic                       div_done;
  logic                       rem_nz;
  logic signed [SUM_W-1:0]    q_s;
  logic signed [SUM_W-1:0]    m_s;
  logic signed [2*DIFF_W-1:0] prod;

  // Square root by two-bit digit recurrence.
  logic [DIV_W-1:0]   sx;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W+1:0]  srem;
  logic [ROOT_W+3:0]  srem_t;
  logic [ROOT_W+3:0]  trial;
  logic               s_ge;
  logic [RC_W-1:0]    scnt;
  logic [STD_W-1:0]   std_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RST;
      threshold     <= THRESHOLD_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WINDOW_LENGTH) window_length <= cfg_data[NUM_W-1:0];
      if (cfg_index == CFG_THRESHOLD)     threshold     <= cfg_data[STD_W-1:0];
    end
  end

  // Decode the head word: group check, window size and newest slot.
  assign it       = qout.item;
  assign g_ok     = (32'(it.group) < MAX_GROUPS);
  assign gidx     = GW'(it.group);
  assign fill_ext = EW'(fill_count[gidx]);
  always_comb begin
    if (window_length == '0) eff = EW'(1);
    else if (32'(window_length) > MAX_WINDOW) eff = EW'(MAX_WINDOW);
    else eff = EW'(window_length);
    if (!g_ok) n_calc = '0;
    else if (fill_ext < eff) n_calc = NUM_W'(fill_ext);
    else n_calc = NUM_W'(eff);
  end
  assign head_pos = (write_pos[gidx] == '0) ? PW'(MAX_WINDOW - 1) : write_pos[gidx] - 1'b1;
  assign wr_addr  = AW'(32'(gidx) * MAX_WINDOW + 32'(write_pos[gidx]));

  assign pos_dec = (pos == '0) ? PW'(MAX_WINDOW - 1) : pos - 1'b1;
  assign rd_addr = AW'(32'(rgidx) * MAX_WINDOW + 32'(pos));
  assign issuing = (issue_cnt != n);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (qout.valid && it.mode == MODE_REPORT) begin
          state_next = (n_calc == '0) ? ST_SQRT_OUT : ST_SUM;
        end
      end
      ST_SUM:      if (rvalid && acc_cnt == n - 1'b1) state_next = ST_MEAN_GO;
      ST_MEAN_GO:  state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_next = ST_SQ;
      ST_SQ:       if (sqr_v && acc_cnt == n - 1'b1) state_next = ST_VAR_GO;
      ST_VAR_GO:   state_next = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_done) state_next = ST_SQRT_OUT;
      ST_SQRT_OUT: if (empty || scnt == '0) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    rd_en  = 1'b0;
    div_go = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop    = qout.valid;
        mem_we = qout.valid && it.mode == MODE_PUSH && g_ok;
      end
      ST_SUM, ST_SQ:         rd_en  = issuing;
      ST_MEAN_GO, ST_VAR_GO: div_go = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Ring bookkeeping on push.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        fill_count[i] <= '0;
        write_pos[i]  <= '0;
      end
    end else if (mem_we) begin
      write_pos[gidx] <= (32'(write_pos[gidx]) == MAX_WINDOW - 1) ? '0
                                                                 : write_pos[gidx] + 1'b1;
      if (32'(fill_count[gidx]) < MAX_WINDOW) fill_count[gidx] <= fill_count[gidx] + 1'b1;
    end
  end

  // Sample memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) ring[wr_addr] <= it.sample;
    if (rd_en)  rdata <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
      diff_v <= 1'b0;
      sqr_v  <= 1'b0;
    end else begin
      rvalid <= rd_en;
      diff_v <= rvalid && state == ST_SQ;
      sqr_v  <= diff_v;
    end
  end

  // Floored mean from the divider result.
  assign q_s    = SUM_W'(quot);
  assign m_s    = sum[SUM_W-1] ? (-q_s - SUM_W'(rem_nz)) : q_s;
  assign div_in = (state == ST_MEAN_GO)
                  ? (sum[SUM_W-1] ? DIV_W'(-sum) : DIV_W'(sum)) : sq_acc;
  assign prod   = diff * diff;

  wmsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_in),
    .divisor  (n),
    .done     (div_done),
    .quot     (quot),
    .rem_nz   (rem_nz)
  );

  assign srem_t  = {srem, sx[DIV_W-1:DIV_W-2]};
  assign trial   = (ROOT_W+4)'({root, 2'b01});
  assign s_ge    = (srem_t >= trial);
  assign std_sat = (root > ROOT_W'(STD_MAX)) ? STD_MAX : STD_W'(root);

  // Walk datapath: accumulate, difference and square, then the root.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      acc_cnt   <= '0;
    end else begin
      if (state == ST_IDLE) begin
        issue_cnt <= '0;
        acc_cnt   <= '0;
      end else if (state == ST_DIV_MEAN && div_done) begin
        issue_cnt <= '0;
        acc_cnt   <= '0;
      end else begin
        if (rd_en) issue_cnt <= issue_cnt + 1'b1;
        if ((state == ST_SUM && rvalid) || (state == ST_SQ && sqr_v)) begin
          acc_cnt <= acc_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && qout.valid) begin
      rgroup    <= it.group;
      rgidx     <= gidx;
      n         <= n_calc;
      start_pos <= head_pos;
      pos       <= head_pos;
      empty     <= (n_calc == '0);
      sum       <= '0;
      sq_acc    <= '0;
      root      <= '0;
    end
    if (rd_en) pos <= pos_dec;
    if (state == ST_SUM && rvalid) sum <= sum + SUM_W'(rdata);
    if (state == ST_DIV_MEAN && div_done) begin
      mean_r <= m_s[SAMPLE_W-1:0];
      pos    <= start_pos;
    end
    if (rvalid) diff <= DIFF_W'(rdata) - DIFF_W'(mean_r);
    if (diff_v) sqr <= prod[SQ_W-1:0];
    if (sqr_v)  sq_acc <= sq_acc + DIV_W'(sqr);
    if (state == ST_DIV_VAR && div_done) begin
      sx   <= quot;
      root <= '0;
      srem <= '0;
      scnt <= RC_W'(ROOT_W);
    end
    if (state == ST_SQRT_OUT && !empty && scnt != '0) begin
      sx   <= {sx[DIV_W-3:0], 2'b00};
      scnt <= scnt - 1'b1;
      if (s_ge) begin
        srem <= (ROOT_W+2)'(srem_t - trial);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        srem <= (ROOT_W+2)'(srem_t);
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == ST_SQRT_OUT) && (empty || scnt == '0);
  end

  always_ff @(posedge clk) begin
    if (state == ST_SQRT_OUT) begin
      group_out    <= rgroup;
      sample_count <= n;
      if (empty) begin
        mean      <= ONE_Q20;
        std_dev   <= '0;
        converged <= 1'b0;
      end else begin
        mean      <= mean_r;
        std_dev   <= std_sat;
        converged <= (std_sat < threshold);
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/windowed_mean_stddev_convergence.sv @@
// Top level of the windowed mean and deviation block.
// Depends on wmsd_pkg, wmsd_front and wmsd_back.
//
// Usage: a command word (mode, group, sample) is taken at a clock edge with
// start high and busy low. Push words store a sample into the group's ring and
// give no result; report words give one result word on group_out, mean,
// std_dev, sample_count and converged, marked by done for one cycle.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// window_length (index 0) and threshold (index 1); it is always ready
// and should be used only while no report is in flight.
// A report on n samples is worked in order: the word is popped, the window is
// walked through the single read port of the sample memory for the sum, the
// shared 60-bit bit-serial divider gives the mean, the window is walked again
// for the squares, the divider gives the variance, the bit-serial square root
// runs, and the result is registered. An empty report goes straight to the
// result. The back end takes a push word whenever it is idle; a report holds
// the queue until its result is registered.
// A two-word queue between front and back keeps start accepted while the
// back end walks; busy rises when it is full.
// Reset clears fill counts, ring positions, queue, state and configuration registers; the sample
// memory is left as is, since only written entries are ever read.
// The receiver cannot stall: every result is shown exactly once.
`timescale 1ns / 1ps
`default_nettype none
module windowed_mean_stddev_convergence #(
  parameter int unsigned MAX_GROUPS = wmsd_pkg::MAX_GROUPS_DEF,
  parameter int unsigned MAX_WINDOW = wmsd_pkg::MAX_WINDOW_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           start,
  output logic                          busy,
  input  wire                           mode,
  input  wire [3:0]                     group,
  input  wire signed [23:0]             sample,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [wmsd_pkg::CFGIDX_W-1:0]  cfg_index,
  input  wire [wmsd_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic [3:0]                    group_out,
  output logic signed [23:0]            mean,
  output logic [22:0]                   std_dev,
  output logic [10:0]                   sample_count,
  output logic                          converged
);
  import wmsd_pkg::*;

  queue_out_t qout;
  logic       pop;

  // Front end: command queue.
  wmsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_mode   (mode),
    .in_group  (group),
    .in_sample (sample),
    .busy      (busy),
    .pop       (pop),
    .qout      (qout)
  );

  // Back end: storage and statistics.
  wmsd_back #(
    .MAX_GROUPS (MAX_GROUPS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .qout         (qout),
    .pop          (pop),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .group_out    (group_out),
    .mean         (mean),
    .std_dev      (std_dev),
    .sample_count (sample_count),
    .converged    (converged)
  );

endmodule
`default_nettype wire

@@ hw/rtl/wmsd_checker.sv @@
// Port-level checks for the windowed mean and deviation block, with its bind.
// Depends on wmsd_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module wmsd_checker (
  input wire               clk,
  input wire               rst,
  input wire               busy,
  input wire               done,
  input wire signed [23:0] mean,
  input wire [22:0]        std_dev,
  input wire [10:0]        sample_count,
  input wire               converged
);
  import wmsd_pkg::*;

  // No result word follows directly on another; the sequencer returns to idle between them.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result word shown on two cycles in a row");

  // Reset leaves no result and an empty queue.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done && !busy) else $error("result or busy right after reset");

  // Convergence needs a non-empty window.
  a_conv_nonempty: assert property (@(posedge clk) disable iff (rst)
    done && converged |-> sample_count != 11'd0) else $error("empty window converged");

  // An empty window reports the fixed answer.
  a_empty_answer: assert property (@(posedge clk) disable iff (rst)
    done && sample_count == 11'd0 |-> mean == ONE_Q20 && std_dev == 23'd0)
    else $error("wrong answer for an empty window");

endmodule

bind windowed_mean_stddev_convergence wmsd_checker u_wmsd_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .mean         (mean),
  .std_dev      (std_dev),
  .sample_count (sample_count),
  .converged    (converged)
);
`default_nettype wire
